// ----- rtl/mfq_pkg.sv -----
// package for the minifloat quantizer: payload structs, register indexes
// and the xorshift step; no dependencies
`timescale 1ns / 1ps
package mfq_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_MANT_W = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_EXP_W = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ROUND = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SEED = 2'd3;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        last_in;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        last_out;
  } out_word_t;

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

// ----- rtl/minifloat_quantizer_unit.sv -----
// minifloat quantizer top level: input register, rounding logic, result register
// depends on mfq_pkg
`timescale 1ns / 1ps
// registers from input accept to result valid: input reg, then result reg
// throughput: one word per cycle while the output is not stalled, set by the single-pass rounding logic
// the xorshift state advances at input accept
// reset: registers go to mantissa 7, exponent 8, nearest rounding, seed/state 1
module minifloat_quantizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mfq_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mfq_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic [mfq_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mfq_pkg::CfgDataW-1:0]  cfg_data
);
  import mfq_pkg::*;

  logic [4:0]  mant_w;
  logic [3:0]  exp_w;
  logic        round_mode;
  logic [31:0] rng;

  logic        s1_valid;
  in_word_t    s1_word;
  logic [31:0] s1_rnd;

  logic        s1_go, in_go;
  logic        seed_we;

  assign s1_go = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign in_go = in_valid && in_ready;
  assign seed_we = cfg_we && (cfg_index == REG_SEED);

  // quantize logic
  logic [4:0]  mw, k;
  logic [3:0]  ew;
  logic [8:0]  bias, max_exp;
  logic [7:0]  e;
  logic [22:0] m;
  logic        sgn;
  logic signed [10:0] mexp;
  logic [22:0] kmask;
  logic [23:0] sum;
  logic [23:0] mant;
  logic [23:0] mw_lim;
  logic [9:0]  oexp;
  logic [31:0] result;
  logic [22:0] frac;

  always_comb begin
    mw = (mant_w > 5'd23) ? 5'd23 : mant_w;
    ew = (exp_w == 4'd0) ? 4'd1 : ((exp_w > 4'd8) ? 4'd8 : exp_w);
    k = 5'd23 - mw;
    bias = (9'd1 << (ew - 4'd1)) - 9'd1;
    max_exp = (9'd1 << ew) - 9'd1;
    sgn = s1_word.value_bits[31];
    e = s1_word.value_bits[30:23];
    m = s1_word.value_bits[22:0];
    mexp = $signed({3'b000, e}) - 11'sd127 + $signed({2'b00, bias});
    kmask = 23'((24'd1 << k) - 24'd1);
    mw_lim = 24'd1 << mw;
    sum = {1'b0, m};
    oexp = 10'(mexp) - {1'b0, bias} + 10'd127;
    mant = 24'd0;
    if ($signed({2'b00, max_exp}) < mexp) begin
      mant = mw_lim - 24'd1;
      oexp = {1'b0, max_exp} - {1'b0, bias} + 10'd127;
    end else begin
      if (k == 5'd0) begin
        sum = {1'b0, m};
      end else if (round_mode) begin
        sum = {1'b0, m} + {1'b0, s1_rnd[22:0] & kmask};
      end else begin
        sum = {1'b0, m} + (24'd1 << (k - 5'd1));
      end
      mant = sum >> k;
      if ((mant & ~(mw_lim - 24'd1)) != 24'd0) begin
        mant = 24'd0;
        oexp = oexp + 10'd1;
      end
    end
    frac = 23'(mant << k);
    if (e == 8'd0 || mexp < 0) begin
      result = 32'd0;
    end else if (oexp > 10'd254) begin
      result = {sgn, 8'hFF, 23'd0};
    end else begin
      result = {sgn, oexp[7:0], frac};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mant_w <= 5'd7;
      exp_w <= 4'd8;
      round_mode <= 1'b0;
      rng <= 32'd1;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MANT_W: mant_w <= cfg_data[4:0];
          REG_EXP_W: exp_w <= cfg_data[3:0];
          REG_ROUND: round_mode <= cfg_data[0];
          REG_SEED: rng <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
      // a seed load wins over the per-word advance
      if (in_go && !seed_we) begin
        rng <= xorshift(rng);
      end
      if (in_go) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_go) begin
      s1_word <= in_data;
      s1_rnd <= xorshift(rng);
    end
    if (s1_go) begin
      out_data.result_bits <= result;
      out_data.last_out <= s1_word.last_in;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");
  a_rng: assert property (@(posedge clk) disable iff (rst)
    rng != 32'd0)
    else $error("random state stuck at zero");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty stage");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for minifloat_quantizer_unit: drives fp32 words through the quantizer
// under random idling and checks each result against an in-bench predictor
// depends on mfq_pkg and the rtl top level
`timescale 1ns / 1ps

class quant_scoreboard;
  bit [4:0]  mant_w;
  bit [3:0]  exp_w;
  bit        stoch;
  bit [31:0] rng;
  mfq_pkg::out_word_t pending[$];
  int        errors;

  function new();
    mant_w = 7;
    exp_w = 8;
    stoch = 0;
    rng = 1;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      mfq_pkg::REG_MANT_W: mant_w = val[4:0];
      mfq_pkg::REG_EXP_W:  exp_w = val[3:0];
      mfq_pkg::REG_ROUND:  stoch = val[0];
      mfq_pkg::REG_SEED:   rng = (val == 0) ? 32'd1 : val;
      default: ;
    endcase
  endfunction

  // predicts the quantized word and queues it
  function void note_input(mfq_pkg::in_word_t w);
    bit [31:0] x, q, mant, mask;
    int mw, ew, k, bias, maxe, mexp, oexp;
    bit [7:0] e;
    bit [22:0] m;
    bit s;
    mfq_pkg::out_word_t o;
    x = rng ^ (rng << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    rng = x;
    s = w.value_bits[31];
    e = w.value_bits[30:23];
    m = w.value_bits[22:0];
    mw = (mant_w > 23) ? 23 : mant_w;
    ew = (exp_w == 0) ? 1 : ((exp_w > 8) ? 8 : exp_w);
    k = 23 - mw;
    bias = (1 << (ew - 1)) - 1;
    maxe = (1 << ew) - 1;
    mexp = int'(e) - 127 + bias;
    if (e == 0 || mexp < 0) begin
      q = 0;
    end else begin
      if (mexp > maxe) begin
        mant = (32'd1 << mw) - 1;
        oexp = maxe - bias + 127;
      end else begin
        mask = (32'd1 << k) - 1;
        if (k == 0) mant = {9'd0, m};
        else if (stoch) mant = ({9'd0, m} + (rng & mask)) >> k;
        else mant = ({9'd0, m} + (32'd1 << (k - 1))) >> k;
        oexp = mexp - bias + 127;
        if ((mant >> mw) != 0) begin
          mant = 0;
          oexp = oexp + 1;
        end
      end
      if (oexp > 254) q = {s, 31'h7F800000};
      else q = {s, 31'd0} | (32'(oexp) << 23) | ((mant << k) & 32'h7FFFFF);
    end
    o.result_bits = q;
    o.last_out = w.last_in;
    pending.push_back(o);
  endfunction

  function void check_result(mfq_pkg::out_word_t got);
    mfq_pkg::out_word_t exp_w_;
    if (pending.size() == 0) begin
      $display("%0t: unexpected word exp none act %h", $time, got);
      errors++;
      return;
    end
    exp_w_ = pending.pop_front();
    if (got.result_bits !== exp_w_.result_bits) begin
      $display("%0t: result_bits exp %h act %h", $time, exp_w_.result_bits, got.result_bits);
      errors++;
    end
    if (got.last_out !== exp_w_.last_out) begin
      $display("%0t: last_out exp %b act %b", $time, exp_w_.last_out, got.last_out);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  mfq_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  mfq_pkg::out_word_t out_data;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  bit hold_off = 0;
  bit long_stall_done = 0;
  quant_scoreboard sb = new();

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  minifloat_quantizer_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // receiver: random stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (hold_off) out_ready <= 0;
    else if ($urandom_range(0, 9) < 3) out_ready <= ($urandom_range(0, 3) == 0);
    else if ($urandom_range(0, 9) < 2) out_ready <= 1;
  end

  initial begin
    @(posedge clk);
    while (sb.pending.size() == 0) @(posedge clk);
    repeat (300) @(posedge clk);
    hold_off = 1;
    repeat (60) @(posedge clk);
    hold_off = 0;
    long_stall_done = 1;
  end

  // ready is read mid-cycle, where it already holds its value for the next edge
  task automatic send_word(logic [31:0] v, logic l);
    mfq_pkg::in_word_t w;
    w.value_bits = v;
    w.last_in = l;
    in_valid <= 1;
    in_data <= w;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sb.note_input(w);
  endtask

  task automatic send_gap();
    in_valid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(int mw, int ew, int rm, logic [31:0] seed);
    drain();
    write_reg(mfq_pkg::REG_MANT_W, mw);
    write_reg(mfq_pkg::REG_EXP_W, ew);
    write_reg(mfq_pkg::REG_ROUND, rm);
    write_reg(mfq_pkg::REG_SEED, seed);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_value(int ew);
    logic [31:0] v;
    int c;
    v = $urandom;
    c = $urandom_range(0, 9);
    // center exponents near the minifloat range so all paths show up
    if (c < 6) v[30:23] = 8'(127 + $urandom_range(0, 1 << ew) - (1 << (ew - 1)) - 1);
    else if (c == 6) v[30:23] = 0;
    else if (c == 7) v[30:23] = 8'hFF;
    else if (c == 8) v[22:0] = $urandom_range(0, 1) ? 23'h7FFFFF : 23'h400000;
    return v;
  endfunction

  initial begin
    logic [31:0] dir_vals[] = '{32'h0, 32'h80000000, 32'h00000001, 32'h3F800000,
      32'hBF800000, 32'h3FFFFFFF, 32'h3F808000, 32'h3F80C000, 32'h7F7FFFFF,
      32'hFF7FFFFF, 32'h7F800000, 32'hFFC00000, 32'h7FFFFFFF, 32'h00800000,
      32'h3F7FFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h4B7FFFFF};
    int n, mw, ew, burst;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir_vals[i]) send_word(dir_vals[i], i[0]);
    configure(0, 1, 0, 0);
    foreach (dir_vals[i]) send_word(dir_vals[i], i[1]);
    configure(23, 8, 1, 32'hFFFFFFFF);
    send_word(32'h3F800001, 1);
    send_word(32'hC0123456, 0);
    configure(31, 15, 1, 32'h1234);
    send_word(32'h3F812345, 0);
    send_word(32'h7F800000, 1);
    configure(3, 0, 0, 5);
    send_word(32'h3FC00000, 0);
    n = 0;
    while (n < 1950) begin
      if (n % 200 == 0) begin
        mw = $urandom_range(0, 23);
        ew = $urandom_range(1, 8);
        if (n == 400) begin mw = 23; ew = 8; end
        if (n == 600) begin mw = 0; ew = 1; end
        configure(mw, ew, $urandom_range(0, 1), $urandom);
      end
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        send_word(rand_value(ew), 1'($urandom_range(0, 1)));
        n++;
      end
      if ($urandom_range(0, 3) != 0) send_gap();
    end
    in_valid <= 0;
    wait (long_stall_done);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end
endmodule

// ----- minifloat_quantizer_unit.f -----
rtl/mfq_pkg.sv
rtl/minifloat_quantizer_unit.sv
tb/sv/tb_top.sv
